>>> sv/mdc_pkg.sv
// shared types, constants and sine table math for the modulated delay chorus
package mdc_pkg;

	localparam int LINE_DEPTH_DEF      = 8192;
	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int SINE_TABLE_SIZE_DEF = 1024;

	// configuration register indexes
	localparam logic [2:0] REG_BASE_DELAY    = 3'd0;
	localparam logic [2:0] REG_MOD_DEPTH     = 3'd1;
	localparam logic [2:0] REG_LINE_LENGTH   = 3'd2;
	localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd3;
	localparam logic [2:0] REG_WET_MIX       = 3'd4;
	localparam logic [2:0] REG_PHASE_STEP    = 3'd5;
	localparam logic [2:0] REG_START_QUARTER = 3'd6;

	// gain and delay limits
	localparam logic [20:0] BASE_MIN  = 21'd256;
	localparam logic [14:0] FB_MAX    = 15'd31129;
	localparam logic [15:0] WET_MAX   = 16'd32768;
	localparam logic [15:0] WET_BYP   = 16'd16;
	localparam logic [13:0] LEN_MIN   = 14'd4;

	// odd polynomial for sin(pi/2 * x), Q30
	localparam longint POLY_C1 = 64'sd1686447685;
	localparam longint POLY_C3 = 64'sd690662111;
	localparam longint POLY_C5 = 64'sd78071983;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BYPASS,
		ST_LFO,
		ST_MAG,
		ST_ADDR,
		ST_DSTART,
		ST_DIV,
		ST_POS,
		ST_RD0,
		ST_RD1,
		ST_INTERP,
		ST_FB,
		ST_MIX1,
		ST_MIX2
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic idle;
		logic load_in;
		logic lfo_en;
		logic mag_en;
		logic addr_en;
		logic div_start;
		logic pos_en;
		logic rd0;
		logic rd1;
		logic interp_en;
		logic fb_en;
		logic mix1_en;
		logic out_load;
		logic out_byp;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic out_free;
		logic bypass;
	} status_t;

	// quarter-wave sine entry in Q0.15 from the Q30 argument
	function automatic logic [14:0] sine_poly(input longint x);
		longint x2;
		longint inner;
		longint outer;
		longint v;
		x2    = (x * x) >>> 30;
		inner = POLY_C3 - ((POLY_C5 * x2) >>> 30);
		outer = POLY_C1 - ((x2 * inner) >>> 30);
		v     = (x * outer) >>> 30;
		v     = (v + 64'sd16384) >>> 15;
		if (v > 64'sd32767)
			v = 64'sd32767;
		return v[14:0];
	endfunction

endpackage

>>> sv/modulated_delay_chorus.sv
// top level of the modulated delay chorus: configuration registers and unit wiring
//
// feedback chorus on a linearly interpolated delay line driven by a sine lfo.
// one signed sample in gives one sample out. after reset the delay store is
// swept to zero, one entry a cycle, and no sample is taken until all
// LINE_DEPTH entries (8192 by default) are clear; configuration writes are
// taken at any time. a sample whose wet_mix is 16 or less comes back
// unchanged. for any other sample the read position is reduced modulo the
// ring length by a bit-serial remainder unit, one bit of the read-distance
// magnitude (23 bits by default) per cycle, and the two interpolation taps
// come through the single store read port in turn. in_stall is low only
// while the sequencer is idle; a finished result waits in the output
// register while the next sample is already accepted.
module modulated_delay_chorus import mdc_pkg::*; #(
	parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// sample output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	localparam int PTR_W = $clog2(LINE_DEPTH);
	localparam int LEN_W = PTR_W + 1;

	// configuration registers
	logic [20:0] base_delay_q;
	logic [20:0] mod_depth_q;
	logic [13:0] line_length_q;
	logic [14:0] feedback_gain_q;
	logic [15:0] wet_mix_q;
	logic [31:0] phase_step_q;
	logic        start_quarter_q;

	// the user issues writes only while idle; the block does not enforce it, and the port is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q    <= BASE_MIN;
			mod_depth_q     <= '0;
			line_length_q   <= 14'd8192;
			feedback_gain_q <= '0;
			wet_mix_q       <= '0;
			phase_step_q    <= '0;
			start_quarter_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_DELAY:    base_delay_q    <= cfg_data[20:0];
				REG_MOD_DEPTH:     mod_depth_q     <= cfg_data[20:0];
				REG_LINE_LENGTH:   line_length_q   <= cfg_data[13:0];
				REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[14:0];
				REG_WET_MIX:       wet_mix_q       <= cfg_data[15:0];
				REG_PHASE_STEP:    phase_step_q    <= cfg_data;
				REG_START_QUARTER: start_quarter_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped working values
	logic [20:0]      base_eff;
	logic [14:0]      fb_eff;
	logic [15:0]      wet_eff;
	logic [LEN_W-1:0] len_eff;
	logic             bypass;

	always_comb begin
		base_eff = (base_delay_q < BASE_MIN) ? BASE_MIN : base_delay_q;
		fb_eff   = (feedback_gain_q > FB_MAX) ? FB_MAX : feedback_gain_q;
		wet_eff  = (wet_mix_q > WET_MAX) ? WET_MAX : wet_mix_q;
		// ring length held between four entries and the full store
		if (line_length_q < LEN_MIN)
			len_eff = LEN_W'(LEN_MIN);
		else if (32'(line_length_q) > 32'(LINE_DEPTH))
			len_eff = LEN_W'(LINE_DEPTH);
		else
			len_eff = LEN_W'(line_length_q);
		// near-zero wet gain passes the dry sample straight through
		bypass = (wet_mix_q <= WET_BYP);
	end

	cmd_t    cmd;
	status_t status;

	mdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd)
	);

	assign in_stall = !cmd.idle;

	mdc_datapath #(
		.LINE_DEPTH      (LINE_DEPTH),
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_SIZE (SINE_TABLE_SIZE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.base_eff   (base_eff),
		.depth      (mod_depth_q),
		.len        (len_eff),
		.fb         (fb_eff),
		.wet        (wet_eff),
		.step       (phase_step_q),
		.sq         (start_quarter_q),
		.bypass     (bypass),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);
endmodule

>>> sv/mdc_mod.sv
// iterative restoring remainder unit, one dividend bit per cycle
module mdc_mod import mdc_pkg::*; #(
	parameter int DW = 24,
	parameter int MW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [MW-1:0] divisor,
	output logic          done,
	output logic [MW-1:0] rem
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [MW-1:0] rem_q;
	logic [MW:0]   shifted;
	logic [MW:0]   trial;

	always_comb begin
		shifted = {rem_q, dvd_q[DW-1]};
		trial   = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			// remainder stays below the divisor, so the shifted value fits MW+1 bits
			if (shifted >= {1'b0, divisor})
				rem_q <= trial[MW-1:0];
			else
				rem_q <= shifted[MW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

>>> sv/mdc_ctrl.sv
// sequencing state machine for one sample
module mdc_ctrl import mdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output cmd_t    cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = status.bypass ? ST_BYPASS : ST_LFO;
				end
			end
			ST_BYPASS: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_byp  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_LFO: begin
				cmd.lfo_en = 1'b1;
				state_d    = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag_en = 1'b1;
				state_d    = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr_en = 1'b1;
				state_d     = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done)
					state_d = ST_POS;
			end
			ST_POS: begin
				cmd.pos_en = 1'b1;
				state_d    = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.interp_en = 1'b1;
				state_d       = ST_FB;
			end
			ST_FB: begin
				cmd.fb_en = 1'b1;
				state_d   = ST_MIX1;
			end
			ST_MIX1: begin
				cmd.mix1_en = 1'b1;
				state_d     = ST_MIX2;
			end
			ST_MIX2: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule

>>> sv/mdc_datapath.sv
// lfo, read address, delay store, interpolation, feedback and mix arithmetic
module mdc_datapath import mdc_pkg::*; #(
	parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF,
	localparam int PTR_W          = $clog2(LINE_DEPTH),
	localparam int LEN_W          = PTR_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic [20:0]                   base_eff,
	input  logic [20:0]                   depth,
	input  logic [LEN_W-1:0]              len,
	input  logic [14:0]                   fb,
	input  logic [15:0]                   wet,
	input  logic [31:0]                   step,
	input  logic                          sq,
	input  logic                          bypass,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	localparam int SB    = SAMPLE_BITS;
	localparam int MOD_W = LEN_W + 8;
	localparam int MAG_W = ((PTR_W + 8) > 22 ? (PTR_W + 8) : 22) + 1;
	localparam int V_W   = MAG_W + 1;
	localparam int IDX_W = $clog2(SINE_TABLE_SIZE + 1);
	localparam int IP_W  = 30 + IDX_W;
	localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
	localparam longint SMIN = -(64'sd1 <<< (SB - 1));

	// sine table
	logic [14:0] sine_tab [SINE_TABLE_SIZE + 1];
	for (genvar k = 0; k <= SINE_TABLE_SIZE; k++) begin : g_sine
		localparam longint X = (longint'(k) <<< 30) / SINE_TABLE_SIZE;
		assign sine_tab[k] = sine_poly(X);
	end

	logic signed [SB-1:0] x_q;
	logic [31:0]          phase_q;
	logic [PTR_W-1:0]     wp_q;
	logic [PTR_W-1:0]     clr_cnt_q;

	// lfo table read
	logic [31:0]      p_eff;
	logic [IP_W-1:0]  idx_prod;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] rom_addr;
	logic [14:0]      sine_s1;
	logic             sneg_s1;

	always_comb begin
		p_eff    = phase_q + {sq, 30'b0};
		idx_prod = IP_W'(p_eff[29:0]) * IP_W'(SINE_TABLE_SIZE);
		idx      = idx_prod[IP_W-1:30];
		rom_addr = p_eff[30] ? IDX_W'(SINE_TABLE_SIZE) - idx : idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.lfo_en) begin
			sine_s1 <= sine_tab[rom_addr];
			sneg_s1 <= p_eff[31];
		end
	end

	// delay offset from the swing depth
	logic [35:0]        mprod;
	logic signed [22:0] off_q;

	always_comb mprod = 36'(sine_s1) * 36'(depth) + 36'd16384;

	always_ff @(posedge clk) begin
		if (cmd.mag_en)
			off_q <= sneg_s1 ? -$signed({2'b00, mprod[35:15]}) : $signed({2'b00, mprod[35:15]});
	end

	// signed read distance and its magnitude
	logic signed [V_W-1:0] v;
	logic [MAG_W-1:0]      abs_q;
	logic                  vneg_q;

	always_comb
		v = $signed(V_W'({wp_q, 8'b0})) - $signed(V_W'(base_eff)) - V_W'(off_q);

	always_ff @(posedge clk) begin
		if (cmd.addr_en) begin
			vneg_q <= v[V_W-1];
			abs_q  <= v[V_W-1] ? MAG_W'(-v) : MAG_W'(v);
		end
	end

	logic [MOD_W-1:0] modulus;
	logic [MOD_W-1:0] rem;
	logic             div_done;

	assign modulus = {len, 8'b0};

	mdc_mod #(.DW(MAG_W), .MW(MOD_W)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (abs_q),
		.divisor  (modulus),
		.done     (div_done),
		.rem      (rem)
	);

	// read position into the ring
	logic [MOD_W-1:0] rpos;
	logic [PTR_W-1:0] i0;
	logic [LEN_W-1:0] i0_inc;
	logic [PTR_W-1:0] i0_q;
	logic [PTR_W-1:0] i1_q;
	logic [7:0]       frac_q;

	always_comb begin
		rpos   = (vneg_q && rem != '0) ? modulus - rem : rem;
		i0     = rpos[PTR_W+7:8];
		i0_inc = LEN_W'(i0) + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_en) begin
			i0_q   <= i0;
			i1_q   <= (i0_inc == len) ? '0 : i0_inc[PTR_W-1:0];
			frac_q <= rpos[7:0];
		end
	end

	// delay store
	logic [SB-1:0]    store [LINE_DEPTH];
	logic [SB-1:0]    rdata_q;
	logic [PTR_W-1:0] raddr;
	logic [PTR_W-1:0] waddr;
	logic [SB-1:0]    wdata;
	logic             we;
	logic [SB-1:0]    fb_sat;

	always_comb begin
		raddr = cmd.rd1 ? i1_q : i0_q;
		we    = cmd.clr_en | cmd.fb_en;
		waddr = cmd.clr_en ? clr_cnt_q : wp_q;
		wdata = cmd.clr_en ? '0 : fb_sat;
	end

	always_ff @(posedge clk) begin
		if (we)
			store[waddr] <= wdata;
		rdata_q <= store[raddr];
	end

	// linear interpolation
	logic signed [SB-1:0]  s0_q;
	logic signed [SB:0]    diff;
	logic signed [SB+9:0]  iprod;
	logic signed [SB+9:0]  itrim;
	logic signed [SB:0]    dsum;
	logic signed [SB-1:0]  delayed_q;

	always_comb begin
		diff  = $signed({rdata_q[SB-1], rdata_q}) - $signed({s0_q[SB-1], s0_q});
		iprod = (SB+10)'(diff) * $signed({1'b0, frac_q});
		itrim = (iprod + (SB+10)'(128)) >>> 8;
		dsum  = (SB+1)'(s0_q) + itrim[SB:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd1)
			s0_q <= rdata_q;
		if (cmd.interp_en)
			delayed_q <= dsum[SB-1:0];
	end

	// feedback write value
	logic signed [SB+16:0] fprod;
	logic signed [SB+16:0] fsh;
	logic signed [SB+16:0] fsum;

	always_comb begin
		fprod = (SB+17)'(delayed_q) * $signed({1'b0, fb});
		fsh   = (fprod + (SB+17)'(16384)) >>> 15;
		fsum  = fsh + (SB+17)'(x_q);
		if (fsum > (SB+17)'(SMAX))
			fb_sat = SB'(SMAX);
		else if (fsum < (SB+17)'(SMIN))
			fb_sat = SB'(SMIN);
		else
			fb_sat = fsum[SB-1:0];
	end

	// dry and wet mix
	logic [16:0]           dry;
	logic signed [SB+17:0] p1_s1;
	logic signed [SB+17:0] p2;
	logic signed [SB+17:0] tot;
	logic signed [SB-1:0]  mix_sat;

	always_comb begin
		dry = 17'd32768 - 17'(wet);
		p2  = (SB+18)'(delayed_q) * $signed({2'b00, wet});
		tot = (p1_s1 + p2 + (SB+18)'(16384)) >>> 15;
		if (tot > (SB+18)'(SMAX))
			mix_sat = SB'(SMAX);
		else if (tot < (SB+18)'(SMIN))
			mix_sat = SB'(SMIN);
		else
			mix_sat = tot[SB-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mix1_en)
			p1_s1 <= (SB+18)'(x_q) * $signed({1'b0, dry});
		if (cmd.load_in)
			x_q <= sample_in;
	end

	// position, phase and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			wp_q      <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_en)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.mag_en) begin
				phase_q <= phase_q + step;
				if (LEN_W'(wp_q) >= len)
					wp_q <= '0;
			end
			if (cmd.fb_en)
				wp_q <= (LEN_W'(wp_q) + 1'b1 == len) ? '0 : wp_q + 1'b1;
		end
	end

	// output register
	logic          out_valid_q;
	logic [SB-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= cmd.out_byp ? x_q : mix_sat;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	always_comb begin
		status.clr_last = (clr_cnt_q == PTR_W'(LINE_DEPTH - 1));
		status.div_done = div_done;
		status.out_free = !out_valid_q || !out_stall;
		status.bypass   = bypass;
	end
endmodule
